// ===== src/telemetry_frame_byte_stuffer_macros.svh =====
// Assertion macros shared by the telemetry frame byte stuffer.
`ifndef TELEMETRY_FRAME_BYTE_STUFFER_MACROS_SVH
`define TELEMETRY_FRAME_BYTE_STUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
// The condition must hold at every clock edge outside reset.
`define TFBS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("telemetry frame byte stuffer: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TFBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("telemetry frame byte stuffer: assertion failed");
`else
`define TFBS_ASSERT_ALWAYS(label, clk, rst, cond)
`define TFBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/tfbs_pkg.sv =====
`timescale 1ns / 1ps

package tfbs_pkg;

   localparam logic [7:0] HDR_BYTE  = 8'h5E;
   localparam logic [7:0] ESC_BYTE  = 8'h5D;
   localparam logic [7:0] ESC_XOR   = 8'h60;
   localparam logic [7:0] BYTE_MASK = 8'hFF;
   localparam int FRAME_LEN = 7;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
   localparam logic [IDX_W-1:0] HDR_IDX  = '0;

   typedef struct packed {
      logic [7:0]         message_id;
      logic signed [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       end_of_frame;
   } rsp_type;

   typedef logic [7:0] frame_type [FRAME_LEN];

   // 8-bit sum with the carry out folded back into the low bit.
   function automatic logic [7:0] add_end_around(input logic [7:0] acc, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, acc} + {1'b0, b};
      return (s[7:0] & BYTE_MASK) + {7'd0, s[8]};
   endfunction

endpackage

// ===== src/telemetry_frame_byte_stuffer.sv =====
`timescale 1ns / 1ps
// Telemetry frame byte stuffer.
// Input channel (req_): one item carries a message id and a signed 32-bit value.
// Result channel (rsp_): one item per line byte. Each input becomes a frame of
// header 0x5E, the id, four value bytes least significant first and an
// end-around-carry checksum over the first six bytes. After the header, any
// 0x5E or 0x5D byte goes out as 0x5D followed by the byte XOR 0x60; the final
// byte of the frame carries end_of_frame.
// Timing: when the block is idle, an accepted item passes through the input
// register and the frame register before its first byte reaches the output
// register. A frame is 7 to 13 bytes, sent one byte per cycle through the
// output register unless rsp_stall holds it, so the item rate is set by the
// byte serializer. One further item is held in an input register while a frame
// is being sent, so req_stall rises only when that register is full.
// Reset clears all valid and sequencing state; no frame is in flight after it.
// While rsp_stall is high and an output byte is valid, that byte holds and the serializer waits.
`include "telemetry_frame_byte_stuffer_macros.svh"

module telemetry_frame_byte_stuffer
   import tfbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type          hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;
   frame_type        frame_ff, frame_in, built;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             esc_pending_ff, esc_pending_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic       req_accept, out_ready, step, advance, done, load, is_last, needs_esc;
   logic [7:0] cur;
   rsp_type    next_rsp;

   assign req_stall  = hold_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Frame bytes and checksum are built from the held item.
   always_comb begin
      logic [7:0] sum;
      built[0] = HDR_BYTE;
      built[1] = hold_ff.message_id;
      built[2] = hold_ff.payload[7:0];
      built[3] = hold_ff.payload[15:8];
      built[4] = hold_ff.payload[23:16];
      built[5] = hold_ff.payload[31:24];
      sum = built[0];
      for (int i = 1; i < FRAME_LEN - 1; i++) begin
         sum = add_end_around(sum, built[i]);
      end
      built[FRAME_LEN-1] = sum;
   end

   always_comb begin
      cur       = frame_ff[idx_ff];
      is_last   = (idx_ff == LAST_IDX);
      needs_esc = (idx_ff != HDR_IDX) && ((cur == HDR_BYTE) || (cur == ESC_BYTE));
      out_ready = !rsp_valid_ff || !rsp_stall;
      step      = busy_ff && out_ready;
      priority if (esc_pending_ff) begin
         next_rsp.tx_byte      = cur ^ ESC_XOR;
         next_rsp.end_of_frame = is_last;
         advance               = 1'b1;
      end else if (needs_esc) begin
         next_rsp.tx_byte      = ESC_BYTE;
         next_rsp.end_of_frame = 1'b0;
         advance               = 1'b0;
      end else begin
         next_rsp.tx_byte      = cur;
         next_rsp.end_of_frame = is_last;
         advance               = 1'b1;
      end
      done = step && advance && is_last;
      load = hold_valid_ff && (!busy_ff || done);
   end

   always_comb begin
      hold_in       = req_accept ? req_data : hold_ff;
      hold_valid_in = req_accept || (hold_valid_ff && !load);
      priority if (load) begin
         frame_in       = built;
         busy_in        = 1'b1;
         idx_in         = HDR_IDX;
         esc_pending_in = 1'b0;
      end else begin
         frame_in       = frame_ff;
         busy_in        = busy_ff && !done;
         idx_in         = (step && advance && !is_last) ? IDX_W'(idx_ff + 1'b1) : idx_ff;
         esc_pending_in = step ? (!esc_pending_ff && needs_esc) : esc_pending_ff;
      end
      if (out_ready) begin
         rsp_valid_in = busy_ff;
         rsp_in       = next_rsp;
      end else begin
         rsp_valid_in = rsp_valid_ff;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         hold_valid_ff  <= 1'b0;
         busy_ff        <= 1'b0;
         idx_ff         <= HDR_IDX;
         esc_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hold_valid_ff  <= hold_valid_in;
         busy_ff        <= busy_in;
         idx_ff         <= idx_in;
         esc_pending_ff <= esc_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   `TFBS_ASSERT_ALWAYS(a_esc_needs_frame, clock, reset, !esc_pending_ff || busy_ff)
   `TFBS_ASSERT_ALWAYS(a_header_not_escaped, clock, reset, !(esc_pending_ff && idx_ff == HDR_IDX))
   `TFBS_ASSERT_NEXT(a_esc_completes, clock, reset, step && esc_pending_ff, !esc_pending_ff)
   `TFBS_ASSERT_NEXT(a_idle_loads, clock, reset, !busy_ff && hold_valid_ff, busy_ff && idx_ff == HDR_IDX && !hold_valid_ff)

endmodule
